// ===== rtl/core/point_light_voxel_level_defines.svh =====
// Assertion macros used by the lighting pipeline top level.
`ifndef POINT_LIGHT_VOXEL_LEVEL_DEFINES_SVH
`define POINT_LIGHT_VOXEL_LEVEL_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define PLVL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define PLVL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/plvl_pkg.sv =====
package plvl_pkg;

    localparam int COORD_BITS = 20;
    localparam int FRAC_BITS  = 8;
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
    localparam int RAD_BITS   = 16;
    localparam int COL_BITS   = 8;
    localparam int ABS_BITS   = 17;
    localparam int SQ_BITS    = 2 * ABS_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int ROOT_BITS  = 32;
    localparam int NUM_BITS   = COL_BITS + RAD_BITS;
    localparam int NUM_SQRT_CELLS = RAD_BITS;
    localparam int NUM_DIV_CELLS  = COL_BITS;
    localparam int IDX_BITS   = 4;

    localparam logic [IDX_BITS-1:0] REG_LIGHT_X  = 4'd0;
    localparam logic [IDX_BITS-1:0] REG_LIGHT_Y  = 4'd1;
    localparam logic [IDX_BITS-1:0] REG_LIGHT_Z  = 4'd2;
    localparam logic [IDX_BITS-1:0] REG_RADIUS   = 4'd3;
    localparam logic [IDX_BITS-1:0] REG_RED      = 4'd4;
    localparam logic [IDX_BITS-1:0] REG_GREEN    = 4'd5;
    localparam logic [IDX_BITS-1:0] REG_BLUE     = 4'd6;
    localparam logic [IDX_BITS-1:0] REG_ENABLE   = 4'd7;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] voxel_x;
        logic signed [COORD_BITS-1:0] voxel_y;
        logic signed [COORD_BITS-1:0] voxel_z;
    } t_in;

    typedef struct packed {
        logic [COL_BITS-1:0] level_red;
        logic [COL_BITS-1:0] level_green;
        logic [COL_BITS-1:0] level_blue;
        logic                in_volume;
    } t_out;

    typedef struct packed {
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic signed [POS_BITS-1:0] pos_z;
        logic [RAD_BITS-1:0]        radius;
        logic [COL_BITS-1:0]        red;
        logic [COL_BITS-1:0]        green;
        logic [COL_BITS-1:0]        blue;
        logic                       enable;
    } t_cfg;

    typedef struct packed {
        logic [31:0]          rem;
        logic [ROOT_BITS-1:0] root;
        logic [30:0]          sel;
        logic                 lit;
        logic                 in_cube;
    } t_sq;

    typedef struct packed {
        logic [NUM_BITS-1:0] rem_r;
        logic [NUM_BITS-1:0] rem_g;
        logic [NUM_BITS-1:0] rem_b;
        logic [COL_BITS-1:0] q_r;
        logic [COL_BITS-1:0] q_g;
        logic [COL_BITS-1:0] q_b;
        logic [NUM_BITS-1:0] dvs;
        logic                lit;
        logic                in_cube;
    } t_dv;

endpackage

// ===== rtl/core/point_light_voxel_level.sv =====
// Light level of one voxel from a single point light. One request is accepted
// per clock cycle when nothing stalls, and its result passes through three front
// stages (bounding cube test, squares, sum and radius compare), sixteen square
// root cells, one scaling multiply and eight divider cells, one register each.
// Every stage takes a new request as soon as its own content moves on, so a
// stalled output only holds back the stages that are full.
// Configuration must be written only while no request is in flight.
`include "point_light_voxel_level_defines.svh"

module point_light_voxel_level (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  plvl_pkg::t_in                     i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output plvl_pkg::t_out                    o_out,
    input  logic                              i_cfg_we,
    input  logic [plvl_pkg::IDX_BITS-1:0]     i_cfg_index,
    input  logic [plvl_pkg::POS_BITS-1:0]     i_cfg_data
);

    localparam int NS = plvl_pkg::NUM_SQRT_CELLS;
    localparam int ND = plvl_pkg::NUM_DIV_CELLS;

    plvl_pkg::t_cfg r_cfg;

    logic          sq_vld [NS+1];
    logic          sq_rdy [NS+1];
    plvl_pkg::t_sq sq_dat [NS+1];
    logic          dv_vld [ND+1];
    logic          dv_rdy [ND+1];
    plvl_pkg::t_dv dv_dat [ND+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                plvl_pkg::REG_LIGHT_X: r_cfg.pos_x  <= i_cfg_data;
                plvl_pkg::REG_LIGHT_Y: r_cfg.pos_y  <= i_cfg_data;
                plvl_pkg::REG_LIGHT_Z: r_cfg.pos_z  <= i_cfg_data;
                plvl_pkg::REG_RADIUS:  r_cfg.radius <= i_cfg_data[15:0];
                plvl_pkg::REG_RED:     r_cfg.red    <= i_cfg_data[7:0];
                plvl_pkg::REG_GREEN:   r_cfg.green  <= i_cfg_data[7:0];
                plvl_pkg::REG_BLUE:    r_cfg.blue   <= i_cfg_data[7:0];
                plvl_pkg::REG_ENABLE:  r_cfg.enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    plvl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in),
        .o_valid (sq_vld[0]),
        .i_ready (sq_rdy[0]),
        .o_data  (sq_dat[0])
    );

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        plvl_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_vld[k]),
            .o_ready (sq_rdy[k]),
            .i_data  (sq_dat[k]),
            .o_valid (sq_vld[k+1]),
            .i_ready (sq_rdy[k+1]),
            .o_data  (sq_dat[k+1])
        );
    end

    plvl_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (sq_vld[NS]),
        .o_ready (sq_rdy[NS]),
        .i_data  (sq_dat[NS]),
        .o_valid (dv_vld[0]),
        .i_ready (dv_rdy[0]),
        .o_data  (dv_dat[0])
    );

    for (genvar k = 0; k < ND; k++) begin : g_div
        plvl_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_vld[k]),
            .o_ready (dv_rdy[k]),
            .i_data  (dv_dat[k]),
            .o_valid (dv_vld[k+1]),
            .i_ready (dv_rdy[k+1]),
            .o_data  (dv_dat[k+1])
        );
    end

    assign dv_rdy[ND]        = i_out_ready;
    assign o_out_valid       = dv_vld[ND];
    assign o_out.level_red   = dv_dat[ND].lit ? dv_dat[ND].q_r : '0;
    assign o_out.level_green = dv_dat[ND].lit ? dv_dat[ND].q_g : '0;
    assign o_out.level_blue  = dv_dat[ND].lit ? dv_dat[ND].q_b : '0;
    assign o_out.in_volume   = dv_dat[ND].in_cube;

    `PLVL_ASSERT(a_outside_dark, o_out_valid && !o_out.in_volume |-> o_out.level_red == '0 && o_out.level_green == '0 && o_out.level_blue == '0, "Voxel outside the cube is lit")
    `PLVL_ASSERT(a_red_bounded, o_out_valid |-> o_out.level_red <= r_cfg.red, "Red level exceeds the light colour")
    `PLVL_ASSERT(a_off_dark, o_out_valid && !r_cfg.enable |-> o_out.level_blue == '0, "Light off yet blue level nonzero")
    `PLVL_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "Result offered straight after reset")

endmodule

// ===== rtl/core/plvl_front.sv =====
module plvl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plvl_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  plvl_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output plvl_pkg::t_sq   o_data
);

    localparam int PB = plvl_pkg::POS_BITS;
    localparam int CB = plvl_pkg::COORD_BITS;
    localparam int FB = plvl_pkg::FRAC_BITS;
    localparam int AB = plvl_pkg::ABS_BITS;
    localparam int QB = plvl_pkg::SQ_BITS;
    localparam int SB = plvl_pkg::SUM_BITS;
    localparam int RB = plvl_pkg::RAD_BITS;

    logic r_v0, r_v1, r_v2;
    logic rdy0, rdy1, rdy2;

    logic [AB-1:0] r_abs0 [3];
    logic          r_in0, r_lit0;
    logic [QB-1:0] r_sq1 [3];
    logic [2*RB-1:0] r_r2;
    logic          r_in1, r_lit1;
    plvl_pkg::t_sq r_out;

    logic signed [CB-1:0] vox [3];
    logic signed [PB-1:0] pos [3];
    logic [AB-1:0]        n_abs [3];
    logic [3:0]           ok;
    logic [FB:0]          ceil_r;
    logic [SB-1:0]        sum;
    logic                 n_lit0;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign rdy0    = !r_v0 || rdy1;
    assign o_ready = rdy0;
    assign o_valid = r_v2;
    assign o_data  = r_out;

    assign vox[0] = i_data.voxel_x;
    assign vox[1] = i_data.voxel_y;
    assign vox[2] = i_data.voxel_z;
    assign pos[0] = i_cfg.pos_x;
    assign pos[1] = i_cfg.pos_y;
    assign pos[2] = i_cfg.pos_z;
    assign ceil_r = (FB+1)'(((RB+1)'(i_cfg.radius) + (RB+1)'((1 << FB) - 1)) >> FB);

    always_comb begin
        logic signed [CB-1:0] p;
        logic signed [CB+1:0] dv;
        logic signed [CB+1:0] cr;
        logic signed [PB:0]   df;
        logic [PB:0]          mag;
        ok[3] = 1'b1;
        for (int i = 0; i < 3; i++) begin
            p  = CB'(pos[i] >>> FB);
            dv = (CB+2)'(vox[i]) - (CB+2)'(p);
            cr = $signed({{(CB+1-FB){1'b0}}, ceil_r});
            ok[i] = (dv <= cr) && (dv >= -cr);
            df = $signed({vox[i][CB-1], vox[i], 1'b1, {(FB-1){1'b0}}})
                 - $signed({pos[i][PB-1], pos[i]});
            mag = df[PB] ? (PB+1)'(-df) : df;
            n_abs[i] = mag[AB-1:0];
        end
        ok[3] = ok[0] && ok[1] && ok[2];
        n_lit0 = ok[3] && i_cfg.enable && (i_cfg.radius != '0);
    end

    assign sum = SB'(r_sq1[0]) + SB'(r_sq1[1]) + SB'(r_sq1[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_valid) begin
            r_abs0 <= n_abs;
            r_in0  <= ok[3];
            r_lit0 <= n_lit0;
        end
        if (rdy1 && r_v0) begin
            for (int i = 0; i < 3; i++) begin
                r_sq1[i] <= r_abs0[i] * r_abs0[i];
            end
            r_r2  <= i_cfg.radius * i_cfg.radius;
            r_in1 <= r_in0;
            r_lit1 <= r_lit0;
        end
        if (rdy2 && r_v1) begin
            r_out.lit     <= r_lit1 && (sum <= SB'(r_r2));
            r_out.in_cube <= r_in1;
            r_out.rem     <= (r_lit1 && (sum <= SB'(r_r2))) ? sum[31:0] : '0;
            r_out.root    <= '0;
            r_out.sel     <= 31'h4000_0000;
        end
    end

endmodule

// ===== rtl/core/plvl_sqrt_cell.sv =====
module plvl_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  plvl_pkg::t_sq  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output plvl_pkg::t_sq  o_data
);

    logic          r_vld;
    plvl_pkg::t_sq r_data;
    plvl_pkg::t_sq n_data;
    logic [32:0]   trial;
    logic          ge;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    assign trial = {1'b0, i_data.root} + {2'b0, i_data.sel};
    assign ge    = {1'b0, i_data.rem} >= trial;

    always_comb begin
        n_data     = i_data;
        n_data.sel = i_data.sel >> 2;
        if (ge) begin
            n_data.rem  = 32'({1'b0, i_data.rem} - trial);
            n_data.root = (i_data.root >> 1) + 32'(i_data.sel);
        end else begin
            n_data.root = i_data.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== rtl/core/plvl_scale.sv =====
module plvl_scale (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  plvl_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  plvl_pkg::t_sq  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output plvl_pkg::t_dv  o_data
);

    localparam int RB = plvl_pkg::RAD_BITS;
    localparam int NB = plvl_pkg::NUM_BITS;

    logic          r_vld;
    plvl_pkg::t_dv r_data;
    logic [RB-1:0] clip_d;
    logic [RB-1:0] span;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    assign clip_d = (i_data.root > 32'(i_cfg.radius)) ? i_cfg.radius : i_data.root[RB-1:0];
    assign span   = i_cfg.radius - clip_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data.rem_r   <= i_cfg.red * span;
            r_data.rem_g   <= i_cfg.green * span;
            r_data.rem_b   <= i_cfg.blue * span;
            r_data.q_r     <= '0;
            r_data.q_g     <= '0;
            r_data.q_b     <= '0;
            r_data.dvs     <= NB'({i_cfg.radius, 7'b0});
            r_data.lit     <= i_data.lit;
            r_data.in_cube <= i_data.in_cube;
        end
    end

endmodule

// ===== rtl/core/plvl_div_cell.sv =====
module plvl_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  plvl_pkg::t_dv  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output plvl_pkg::t_dv  o_data
);

    logic          r_vld;
    plvl_pkg::t_dv r_data;
    plvl_pkg::t_dv n_data;
    logic          ge_r, ge_g, ge_b;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    assign ge_r = i_data.rem_r >= i_data.dvs;
    assign ge_g = i_data.rem_g >= i_data.dvs;
    assign ge_b = i_data.rem_b >= i_data.dvs;

    always_comb begin
        n_data       = i_data;
        n_data.rem_r = ge_r ? i_data.rem_r - i_data.dvs : i_data.rem_r;
        n_data.rem_g = ge_g ? i_data.rem_g - i_data.dvs : i_data.rem_g;
        n_data.rem_b = ge_b ? i_data.rem_b - i_data.dvs : i_data.rem_b;
        n_data.q_r   = {i_data.q_r[6:0], ge_r};
        n_data.q_g   = {i_data.q_g[6:0], ge_g};
        n_data.q_b   = {i_data.q_b[6:0], ge_b};
        n_data.dvs   = i_data.dvs >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
